// ===== rtl/dtfx_pkg.sv =====
// shared types, character codes and power-of-ten table for the decimal text converter
package dtfx_pkg;

    localparam int MAX_FRAC_DIGITS_DEF = 9;
    localparam int INT_BITS_DEF        = 32;
    localparam int CNT_W               = 4;
    localparam int FIX_FRAC_BITS       = 32;
    localparam int VALUE_W             = 64;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic take;
        logic clear;
    } prs_ctl_t;

    typedef struct packed {
        logic negative;
        logic rejected;
        logic saturated;
    } prs_stat_t;

    function automatic logic [63:0] pow_ten(input logic [CNT_W-1:0] n);
        logic [63:0] p;
        case (n)
            4'd0:    p = 64'd1;
            4'd1:    p = 64'd10;
            4'd2:    p = 64'd100;
            4'd3:    p = 64'd1000;
            4'd4:    p = 64'd10000;
            4'd5:    p = 64'd100000;
            4'd6:    p = 64'd1000000;
            4'd7:    p = 64'd10000000;
            4'd8:    p = 64'd100000000;
            default: p = 64'd1000000000;
        endcase
        return p;
    endfunction

    // bits that hold 10^digits - 1, and 10^digits itself
    function automatic int frac_width(input int digits);
        return $clog2(pow_ten(CNT_W'(digits)));
    endfunction

endpackage

// ===== rtl/dtfx_parser.sv =====
// character parser: whitespace, sign, integer and fraction digit accumulation
module dtfx_parser #(
    parameter int MAX_FRAC_DIGITS = dtfx_pkg::MAX_FRAC_DIGITS_DEF,
    parameter int INT_BITS        = dtfx_pkg::INT_BITS_DEF
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  dtfx_pkg::prs_ctl_t                               ctl,
    input  logic [7:0]                                       ch,
    output dtfx_pkg::prs_stat_t                              stat,
    output logic [INT_BITS-2:0]                              int_accum,
    output logic [dtfx_pkg::frac_width(MAX_FRAC_DIGITS)-1:0] frac_accum,
    output logic [dtfx_pkg::CNT_W-1:0]                       frac_count
);
    import dtfx_pkg::*;

    localparam int INT_W  = INT_BITS - 1;
    localparam int IPW    = INT_W + 4;
    localparam int FRAC_W = frac_width(MAX_FRAC_DIGITS);
    localparam int FPW    = FRAC_W + 4;
    localparam logic [INT_W-1:0] INT_LIMIT = '1;

    typedef enum logic [1:0] {
        PH_WS,
        PH_SIGN,
        PH_INT,
        PH_FRAC
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic                negative_reg, negative_next;
    logic                rejected_reg, rejected_next;
    logic                saturated_reg, saturated_next;
    logic [INT_W-1:0]    int_reg, int_next;
    logic [FRAC_W-1:0]   frac_reg, frac_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    logic                digit;
    logic                blank;
    logic [3:0]          d;
    logic [IPW-1:0]      int_prod;
    logic [FPW-1:0]      frac_prod;

    assign digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign blank = ((ch >= CH_TAB) && (ch <= CH_CR)) || (ch == CH_SPACE);
    assign d     = ch[3:0];

    assign int_prod  = (IPW'(int_reg) << 3) + (IPW'(int_reg) << 1) + IPW'(d);
    assign frac_prod = (FPW'(frac_reg) << 3) + (FPW'(frac_reg) << 1) + FPW'(d);

    always_comb
    begin
        phase_next     = phase_reg;
        negative_next  = negative_reg;
        rejected_next  = rejected_reg;
        saturated_next = saturated_reg;
        int_next       = int_reg;
        frac_next      = frac_reg;
        count_next     = count_reg;
        if (ctl.clear)
        begin
            phase_next     = PH_WS;
            negative_next  = 1'b0;
            rejected_next  = 1'b0;
            saturated_next = 1'b0;
            int_next       = '0;
            frac_next      = '0;
            count_next     = '0;
        end
        else if (ctl.take && !rejected_reg)
        begin
            priority if (phase_reg == PH_WS && blank)
            begin
                phase_next = PH_WS;
            end
            else if (phase_reg == PH_WS && (ch == CH_MINUS || ch == CH_PLUS))
            begin
                negative_next = (ch == CH_MINUS);
                phase_next    = PH_SIGN;
            end
            else if (ch == CH_POINT)
            begin
                if (phase_reg == PH_FRAC)
                begin
                    rejected_next = 1'b1;
                end
                else
                begin
                    phase_next = PH_FRAC;
                end
            end
            else if (!digit)
            begin
                rejected_next = 1'b1;
            end
            else if (phase_reg == PH_FRAC)
            begin
                // digits past the limit are dropped
                if (count_reg < CNT_W'(MAX_FRAC_DIGITS))
                begin
                    frac_next  = FRAC_W'(frac_prod);
                    count_next = count_reg + 1'b1;
                end
            end
            else
            begin
                phase_next = PH_INT;
                if (int_prod > IPW'(INT_LIMIT))
                begin
                    int_next       = INT_LIMIT;
                    saturated_next = 1'b1;
                end
                else
                begin
                    int_next = INT_W'(int_prod);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WS;
            negative_reg  <= 1'b0;
            rejected_reg  <= 1'b0;
            saturated_reg <= 1'b0;
            int_reg       <= '0;
            frac_reg      <= '0;
            count_reg     <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            negative_reg  <= negative_next;
            rejected_reg  <= rejected_next;
            saturated_reg <= saturated_next;
            int_reg       <= int_next;
            frac_reg      <= frac_next;
            count_reg     <= count_next;
        end
    end

    assign stat.negative  = negative_reg;
    assign stat.rejected  = rejected_reg;
    assign stat.saturated = saturated_reg;
    assign int_accum      = int_reg;
    assign frac_accum     = frac_reg;
    assign frac_count     = count_reg;

endmodule

// ===== rtl/dtfx_divider.sv =====
// restoring divider, one quotient bit per cycle, for the fraction scaling
module dtfx_divider #(
    parameter int MAX_FRAC_DIGITS = dtfx_pkg::MAX_FRAC_DIGITS_DEF
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              start,
    input  logic [dtfx_pkg::frac_width(MAX_FRAC_DIGITS)+31:0] numerator,
    input  logic [dtfx_pkg::frac_width(MAX_FRAC_DIGITS)-1:0]  divisor,
    output logic                                              busy,
    output logic [dtfx_pkg::FIX_FRAC_BITS:0]                  quotient
);
    import dtfx_pkg::*;

    localparam int DIV_W = frac_width(MAX_FRAC_DIGITS);
    localparam int NUM_W = DIV_W + FIX_FRAC_BITS;
    localparam int CW    = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg, num_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] div_reg;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DIV_W:0]   trial;
    logic             qbit;

    // remainder stays below the divisor, so one extra bit covers the shift
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign qbit  = (trial >= {1'b0, div_reg});

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            num_next  = numerator;
            rem_next  = '0;
            cnt_next  = CW'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next  = {num_reg[NUM_W-2:0], qbit};
            rem_next  = qbit ? DIV_W'(trial - {1'b0, div_reg}) : DIV_W'(trial);
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign quotient = num_reg[FIX_FRAC_BITS:0];

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && (cnt_reg == CW'(NUM_W)))
        else $error("divider did not start");

    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != '0))
        else $error("divider busy with empty count");

endmodule

// ===== rtl/decimal_text_to_fixed_point.sv =====
// top level: decimal text to signed q32.32 converter with sequencer and output register
//
// input channel s_axis: one ascii character per word in tdata, tlast on the
// final character of a number. output channel m_axis: one word per number,
// tdata = signed q32.32 value, tuser = {overflow, valid_res}.
// a character that is not last is taken in S_IDLE and ready stays high.
// the last character is parsed, the fraction division is set up in S_LOAD,
// the shared restoring divider works through its numerator of
// frac_width(MAX_FRAC_DIGITS) + 32 bits in S_DIV (62 at the default of 9
// digits), and the result is formed in S_DONE.
// a rejected string skips the divider and goes from S_LOAD to S_DONE.
// the divider produces one quotient bit per cycle.
// the result waits in an output register; the next string's characters are
// taken while it waits; the next result holds ready low until it is taken.
// reset clears the parser, the sequencer and the output valid flag.
module decimal_text_to_fixed_point #(
    parameter int MAX_FRAC_DIGITS = dtfx_pkg::MAX_FRAC_DIGITS_DEF,
    parameter int INT_BITS        = dtfx_pkg::INT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // ch
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // value
    output logic [1:0]  m_axis_tuser    // overflow, valid_res
);
    import dtfx_pkg::*;

    localparam int FRAC_W = frac_width(MAX_FRAC_DIGITS);
    localparam int NUM_W  = FRAC_W + FIX_FRAC_BITS;
    localparam int INT_W  = INT_BITS - 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_DONE
    } state_t;

    state_t                  state_reg;
    logic                    m_valid_reg;
    logic [VALUE_W-1:0]      value_reg;
    logic                    valid_res_reg;
    logic                    overflow_reg;

    prs_ctl_t                prs_ctl;
    prs_stat_t               prs_stat;
    logic [INT_W-1:0]        int_accum;
    logic [FRAC_W-1:0]       frac_accum;
    logic [CNT_W-1:0]        frac_count;

    logic                    div_start;
    logic                    div_busy;
    logic [FRAC_W-1:0]       divisor;
    logic [NUM_W-1:0]        numerator;
    logic [FIX_FRAC_BITS:0]  quot;

    logic                    accept;
    logic                    out_free;
    logic [31:0]             hi_part;
    logic [VALUE_W-1:0]      mag;
    logic [VALUE_W-1:0]      result;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign prs_ctl.take  = accept;
    assign prs_ctl.clear = (state_reg == S_DONE) && out_free;

    assign div_start = (state_reg == S_LOAD) && !prs_stat.rejected;
    assign divisor   = FRAC_W'(pow_ten(frac_count));
    // round to nearest: add half the divisor before dividing
    assign numerator = {frac_accum, {FIX_FRAC_BITS{1'b0}}} + NUM_W'(divisor >> 1);

    assign hi_part = 32'(int_accum) + 32'(quot[FIX_FRAC_BITS]);
    assign mag     = {hi_part, quot[FIX_FRAC_BITS-1:0]};
    assign result  = prs_stat.negative ? (~mag + 1'b1) : mag;

    dtfx_parser #(
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS),
        .INT_BITS        (INT_BITS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (prs_ctl),
        .ch         (s_axis_tdata),
        .stat       (prs_stat),
        .int_accum  (int_accum),
        .frac_accum (frac_accum),
        .frac_count (frac_count)
    );

    dtfx_divider #(
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .numerator (numerator),
        .divisor   (divisor),
        .busy      (div_busy),
        .quotient  (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            m_valid_reg   <= 1'b0;
            value_reg     <= '0;
            valid_res_reg <= 1'b0;
            overflow_reg  <= 1'b0;
        end
        else
        begin
            if (m_valid_reg && m_axis_tready && (state_reg != S_DONE))
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && s_axis_tlast)
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    state_reg <= prs_stat.rejected ? S_DONE : S_DIV;
                end
                S_DIV:
                begin
                    if (!div_busy)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        if (prs_stat.rejected)
                        begin
                            value_reg     <= '0;
                            valid_res_reg <= 1'b0;
                            overflow_reg  <= 1'b0;
                        end
                        else
                        begin
                            value_reg     <= result;
                            valid_res_reg <= 1'b1;
                            overflow_reg  <= prs_stat.saturated;
                        end
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        m_valid_reg <= m_valid_reg;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = value_reg;
    assign m_axis_tuser  = {overflow_reg, valid_res_reg};

    a_busy_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == S_DIV))
        else $error("divider running outside division state");

    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_axis_tlast |=> !s_axis_tready)
        else $error("input taken while a number is being finished");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && !valid_res_reg |-> (value_reg == '0) && !overflow_reg)
        else $error("rejected string gave nonzero result");

    a_done_word: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) && out_free |=> m_valid_reg && (state_reg == S_IDLE))
        else $error("result word not presented");

endmodule

// ===== sim/tb_decimal_text_to_fixed_point.sv =====
// self-checking testbench for the decimal text to q32.32 converter
`timescale 1ns / 1ps

module tb_decimal_text_to_fixed_point;
    import dtfx_pkg::*;

    localparam int FRAC_DIGITS = MAX_FRAC_DIGITS_DEF;
    localparam int INT_W       = INT_BITS_DEF;
    localparam logic [63:0] INT_LIMIT = (64'd1 << (INT_W - 1)) - 64'd1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 100;

    typedef enum logic [1:0] {PH_BLANK, PH_SIGNED, PH_INT, PH_FRAC} parse_phase_t;

    typedef struct {
        logic [63:0] value;
        logic        valid_res;
        logic        overflow;
    } fixed_word_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // ch
    logic        s_axis_tlast;   // last
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // value
    logic [1:0]  m_axis_tuser;   // overflow, valid_res

    // parser copy
    parse_phase_t p_phase;
    logic         p_negative;
    logic         p_rejected;
    logic         p_saturated;
    logic [31:0]  p_int;
    logic [29:0]  p_frac;
    logic [3:0]   p_frac_count;

    fixed_word_t  due_values[$];
    logic [7:0]   text_q[$];
    int           mismatches;
    int           chars_sent;
    int           cycles;
    int           stall_left;
    logic         steady;

    decimal_text_to_fixed_point #(
        .MAX_FRAC_DIGITS(FRAC_DIGITS),
        .INT_BITS(INT_W)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("decimal_text_to_fixed_point verification failed");
            $finish;
        end
    end

    task automatic clear_parser();
        p_phase      = PH_BLANK;
        p_negative   = 1'b0;
        p_rejected   = 1'b0;
        p_saturated  = 1'b0;
        p_int        = '0;
        p_frac       = '0;
        p_frac_count = '0;
    endtask

    task automatic absorb_char(input logic [7:0] c, input logic fin);
        logic        is_digit;
        logic        is_blank;
        logic [63:0] grown;
        logic [63:0] div;
        logic [63:0] frac;
        logic [63:0] mag;
        fixed_word_t word;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        is_blank = ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
        if (!p_rejected && !(p_phase == PH_BLANK && is_blank))
        begin
            if (p_phase == PH_BLANK && (c == CH_MINUS || c == CH_PLUS))
            begin
                p_negative = (c == CH_MINUS);
                p_phase    = PH_SIGNED;
            end
            else if (c == CH_POINT)
            begin
                if (p_phase == PH_FRAC)
                    p_rejected = 1'b1;
                else
                    p_phase = PH_FRAC;
            end
            else if (!is_digit)
                p_rejected = 1'b1;
            else if (p_phase == PH_FRAC)
            begin
                if (p_frac_count < FRAC_DIGITS)
                begin
                    p_frac       = 30'(p_frac * 30'd10 + 30'(c - CH_ZERO));
                    p_frac_count = p_frac_count + 4'd1;
                end
            end
            else
            begin
                p_phase = PH_INT;
                grown = {32'd0, p_int} * 64'd10 + 64'(c - CH_ZERO);
                if (grown > INT_LIMIT)
                begin
                    grown       = INT_LIMIT;
                    p_saturated = 1'b1;
                end
                p_int = grown[31:0];
            end
        end
        if (fin)
        begin
            if (p_rejected)
            begin
                word.value     = '0;
                word.valid_res = 1'b0;
                word.overflow  = 1'b0;
            end
            else
            begin
                div = 64'd1;
                repeat (p_frac_count) div = div * 64'd10;
                frac = ((64'(p_frac) << 32) + div / 64'd2) / div;
                mag  = (64'(p_int) << 32) + frac;
                word.value     = p_negative ? (64'd0 - mag) : mag;
                word.valid_res = 1'b1;
                word.overflow  = p_saturated;
            end
            due_values.push_back(word);
            clear_parser();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        mismatches++;
    endtask

    // result checker
    always @(posedge clk)
    begin : check_results
        fixed_word_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (due_values.size() == 0)
                report_mismatch("unexpected word", m_axis_tdata, 64'd0);
            else
            begin
                want = due_values.pop_front();
                if (m_axis_tdata !== want.value)
                    report_mismatch("value", m_axis_tdata, want.value);
                if (m_axis_tuser[0] !== want.valid_res)
                    report_mismatch("valid_res", 64'(m_axis_tuser[0]), 64'(want.valid_res));
                if (m_axis_tuser[1] !== want.overflow)
                    report_mismatch("overflow", 64'(m_axis_tuser[1]), 64'(want.overflow));
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            m_axis_tready = 1'b0;
            stall_left--;
        end
        else if (!steady && $urandom_range(0, 4) == 0)
        begin
            m_axis_tready = 1'b0;
            stall_left    = $urandom_range(0, 3);
        end
        else
            m_axis_tready = 1'b1;
    end

    task automatic send_char(input logic [7:0] c, input logic fin);
        int gap;
        @(negedge clk);
        if (!steady && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid = 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = c;
        s_axis_tlast  = fin;
        do @(posedge clk); while (!s_axis_tready);
        absorb_char(c, fin);
        chars_sent++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    task automatic send_text();
        logic [7:0] c;
        while (text_q.size() > 0)
        begin
            c = text_q.pop_front();
            send_char(c, text_q.size() == 0);
        end
    endtask

    task automatic send_str(input string s);
        add_text(s);
        send_text();
    endtask

    function automatic logic [7:0] any_blank();
        int r;
        r = $urandom_range(9, 14);
        return (r == 14) ? CH_SPACE : 8'(r);
    endfunction

    function automatic logic [7:0] any_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    task automatic build_number();
        int n_int;
        int n_frac;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) text_q.push_back(any_blank());
        case ($urandom_range(0, 2))
            0: text_q.push_back(CH_PLUS);
            1: text_q.push_back(CH_MINUS);
            default: ;
        endcase
        n_int = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 12) : $urandom_range(0, 6);
        repeat (n_int) text_q.push_back(any_digit());
        if ($urandom_range(0, 3) != 0)
        begin
            text_q.push_back(CH_POINT);
            n_frac = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 13)
                                                 : $urandom_range(0, 9);
            repeat (n_frac) text_q.push_back(any_digit());
        end
        if (text_q.size() == 0)
            text_q.push_back(any_digit());
    endtask

    task automatic test_plain_numbers();
        send_str("0");
        send_str("+42");
        send_str("-0");
        send_str("123.456");
        send_str("\t-3.25");
    endtask

    task automatic test_point_forms();
        send_str(".5");
        send_str("-.5");
        send_str("5.");
        send_str(".");
    endtask

    task automatic test_empty_forms();
        for (int c = CH_TAB; c <= CH_CR; c++)
            text_q.push_back(8'(c));
        text_q.push_back(CH_SPACE);
        send_text();
        send_str("-");
        send_str("+");
    endtask

    task automatic test_saturation();
        send_str("2147483647");
        send_str("2147483648");
        send_str("-99999999999.5");
    endtask

    task automatic test_fraction_limit();
        send_str("0.999999999");
        send_str("1.1234567891234");
    endtask

    task automatic test_rejections();
        send_str("1.2.3");
        send_str("+-1");
        send_str(" 1 ");
        send_str("1a");
        text_q.push_back(8'h00);
        send_text();
        text_q.push_back(8'hFF);
        add_text("1");
        send_text();
    endtask

    task automatic test_random_strings();
        int pick;
        int idx;
        while (chars_sent < 430)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                build_number();
            else if (pick < 9)
            begin
                build_number();
                idx = $urandom_range(0, text_q.size() - 1);
                if ($urandom_range(0, 1) == 0)
                    text_q[idx] = 8'($urandom_range(0, 255));
                else
                    text_q.insert(idx, CH_POINT);
            end
            else
                repeat ($urandom_range(1, 5)) text_q.push_back(8'($urandom_range(0, 255)));
            send_text();
        end
    endtask

    task automatic test_back_to_back();
        steady = 1'b1;
        repeat (12)
        begin
            build_number();
            send_text();
        end
    endtask

    task automatic finish_run();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        s_axis_tlast  = 1'b0;
        while (due_values.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("decimal_text_to_fixed_point verification clean");
        else
            $display("decimal_text_to_fixed_point verification failed");
        $finish;
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        mismatches    = 0;
        chars_sent    = 0;
        cycles        = 0;
        stall_left    = 0;
        steady        = 1'b0;
        clear_parser();
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_plain_numbers();
        test_point_forms();
        test_empty_forms();
        test_saturation();
        test_fraction_limit();
        test_rejections();
        test_random_strings();
        test_back_to_back();
        finish_run();
    end

endmodule
